// ===== rtl/idq_pkg.sv =====
// Shared operation and status codes for the indexed double-ended queue.
`timescale 1ns / 1ps

package idq_pkg;

  localparam int unsigned OP_W  = 3;
  localparam int unsigned POS_W = 6;
  localparam int unsigned ST_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_WRITE      = 3'd5,
    OP_CLEAR      = 3'd6
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

endpackage

// ===== rtl/idq_store.sv =====
// Entry store: one write port and one read port with a registered read.
`timescale 1ns / 1ps

module idq_store #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [ENTRY_WIDTH-1:0]   wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [ENTRY_WIDTH-1:0]   rdata_o
);

  logic [ENTRY_WIDTH-1:0] mem [DEPTH];
  logic [ENTRY_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/indexed_double_ended_queue.sv =====
// Bounded double-ended queue of entry handles with access by logical index.
// The result is registered and appears in the cycle after the input transfer.
// One op per cycle unless the output stalls; at most one store access per op.
// The circular store is addressed through a front offset, so no entry ever moves.
// Reset clears the count and front offset; the store contents stay undefined.
`timescale 1ns / 1ps

module indexed_double_ended_queue #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [idq_pkg::OP_W-1:0]         operation_i,
  input  logic [idq_pkg::POS_W-1:0]        position_i,
  input  logic [ENTRY_WIDTH-1:0]           entry_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ENTRY_WIDTH-1:0]           entry_out_o,
  output logic [$clog2(DEPTH+1)-1:0]       count_after_o,
  output logic [idq_pkg::ST_W-1:0]         status_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > idq_pkg::POS_W) ? CW : idq_pkg::POS_W;

  logic                     in_fire;
  logic [CW-1:0]            count_q, count_d;
  logic [AW-1:0]            front_q, front_d;
  logic [AW-1:0]            front_inc, front_dec;
  logic [AW-1:0]            logical;
  logic [AW:0]              slot_sum;
  logic [AW-1:0]            slot;
  logic [AW-1:0]            mem_addr;
  logic                     use_dec;
  logic                     we, re;
  logic                     full, empty, in_range;
  idq_pkg::status_e         status;

  logic                     out_valid_q;
  logic                     from_mem_q;
  logic [CW-1:0]            count_out_q;
  idq_pkg::status_e         status_q;
  logic [ENTRY_WIDTH-1:0]   rdata;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign in_range  = (CMPW'(position_i) < CMPW'(count_q));
  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;

  always_comb begin
    slot_sum = {1'b0, front_q} + {1'b0, logical};
    if (slot_sum >= (AW + 1)'(DEPTH)) begin
      slot_sum = slot_sum - (AW + 1)'(DEPTH);
    end
    slot     = slot_sum[AW-1:0];
    mem_addr = use_dec ? front_dec : slot;
  end

  always_comb begin
    status  = idq_pkg::ST_OK;
    we      = 1'b0;
    re      = 1'b0;
    use_dec = 1'b0;
    logical = '0;
    count_d = count_q;
    front_d = front_q;
    case (idq_pkg::op_e'(operation_i))
      idq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status = idq_pkg::ST_FULL;
        end else begin
          logical = AW'(count_q);
          we      = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      idq_pkg::OP_POP_BACK: begin
        if (empty) begin
          status = idq_pkg::ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
          logical = AW'(count_d);
          re      = 1'b1;
        end
      end
      idq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status = idq_pkg::ST_FULL;
        end else begin
          use_dec = 1'b1;
          front_d = front_dec;
          we      = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      idq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status = idq_pkg::ST_EMPTY;
        end else begin
          re      = 1'b1;
          front_d = front_inc;
          count_d = count_q - 1'b1;
        end
      end
      idq_pkg::OP_READ: begin
        if (!in_range) begin
          status = idq_pkg::ST_RANGE;
        end else begin
          logical = AW'(position_i);
          re      = 1'b1;
        end
      end
      idq_pkg::OP_WRITE: begin
        if (!in_range) begin
          status = idq_pkg::ST_RANGE;
        end else begin
          logical = AW'(position_i);
          we      = 1'b1;
        end
      end
      idq_pkg::OP_CLEAR: begin
        count_d = '0;
        front_d = '0;
      end
      default: begin
      end
    endcase
  end

  idq_store #(
    .DEPTH      (DEPTH),
    .ENTRY_WIDTH(ENTRY_WIDTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (in_fire && we),
    .waddr_i(mem_addr),
    .wdata_i(entry_value_i),
    .re_i   (in_fire && re),
    .raddr_i(mem_addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      front_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        front_q     <= front_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      from_mem_q  <= re;
      count_out_q <= count_d;
      status_q    <= status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_out_o   = from_mem_q ? rdata : '0;
  assign count_after_o = count_out_q;
  assign status_o      = status_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("Accepted operation did not produce a result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_after_o <= CW'(DEPTH)))
    else $error("Reported count exceeds the store depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != idq_pkg::ST_OK)) |-> (entry_out_o == '0))
    else $error("Flagged operation returned a nonzero entry.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && full && ((operation_i == idq_pkg::OP_PUSH_BACK) ||
      (operation_i == idq_pkg::OP_PUSH_FRONT))) |=>
      ((status_o == idq_pkg::ST_FULL) && (count_q == CW'(DEPTH))))
    else $error("Push into a full queue was not flagged or changed state.");
`endif

endmodule
